>>> hdl/sync_length_checksum_frame_parser_defines.svh
// Assertion helpers for the frame parser; all checks run on clk, off in rst.
`ifndef SYNC_LENGTH_CHECKSUM_FRAME_PARSER_DEFINES_SVH
`define SYNC_LENGTH_CHECKSUM_FRAME_PARSER_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define SLCFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define SLCFP_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> hdl/slcfp_pkg.sv
package slcfp_pkg;

  localparam int MAX_PAYLOAD_DEF = 64;
  localparam int CFG_INDEX_W     = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_FIRST  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_SECOND = CFG_INDEX_W'(1);

  localparam logic [7:0] SYNC_FIRST_RST  = 8'd170;
  localparam logic [7:0] SYNC_SECOND_RST = 8'd85;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_GOOD   = 3'd1,
    EV_BADSUM = 3'd2,
    EV_OVER   = 3'd3,
    EV_RESYNC = 3'd4
  } frame_event_t;

  typedef struct packed {
    logic         payload_valid;
    logic [7:0]   payload_byte;
    logic [7:0]   payload_index;
    frame_event_t frame_event;
    logic [31:0]  good_frame_count;
  } result_t;

endpackage

>>> hdl/slcfp_in_reg.sv
module slcfp_in_reg
  import slcfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] rx_byte,
  input  logic       take,
  output logic       full,
  output logic [7:0] byte_q
);

  // Accept a new item in the same cycle the held one moves on.
  assign byte_ready = !full || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      byte_q <= rx_byte;
    end
  end

endmodule

>>> hdl/slcfp_parser.sv
module slcfp_parser
  import slcfp_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  logic [7:0] sync_first,
  input  logic [7:0] sync_second,
  output result_t    res
);

  localparam logic [7:0] MaxIdx = 8'(MAX_PAYLOAD);

  phase_t      phase, phase_next;
  logic [7:0]  previous_byte;
  logic [7:0]  frame_length, frame_length_next;
  logic [7:0]  byte_index, byte_index_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [31:0] frame_counter, frame_counter_next;

  logic pair_seen;
  logic in_frame;
  logic room;

  assign pair_seen = (previous_byte == sync_first) && (rx_byte == sync_second);
  assign in_frame  = byte_index < frame_length;
  assign room      = byte_index < MaxIdx;

  always_comb begin
    phase_next = PH_HUNT;
    case (phase)
      PH_HUNT: phase_next = pair_seen ? PH_LEN : PH_HUNT;
      PH_LEN:  phase_next = PH_DATA;
      PH_DATA: begin
        if (pair_seen) begin
          phase_next = PH_LEN;
        end else if (in_frame && room) begin
          phase_next = PH_DATA;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      default: phase_next = PH_HUNT;
    endcase
  end

  always_comb begin
    frame_length_next  = frame_length;
    running_sum_next   = running_sum;
    byte_index_next    = 8'd0;
    frame_counter_next = frame_counter;
    res.payload_valid  = 1'b0;
    res.payload_byte   = 8'd0;
    res.payload_index  = 8'd0;
    res.frame_event    = EV_NONE;
    case (phase)
      PH_LEN: begin
        frame_length_next = rx_byte;
        running_sum_next  = rx_byte;
      end
      PH_DATA: begin
        if (pair_seen) begin
          res.frame_event = EV_RESYNC;
        end else if (in_frame) begin
          if (room) begin
            res.payload_valid = 1'b1;
            res.payload_byte  = rx_byte;
            res.payload_index = byte_index;
            running_sum_next  = running_sum + rx_byte;
            byte_index_next   = byte_index + 8'd1;
          end else begin
            res.frame_event = EV_OVER;
          end
        end else if (running_sum == rx_byte) begin
          frame_counter_next = frame_counter + 32'd1;
          res.frame_event    = EV_GOOD;
        end else begin
          res.frame_event = EV_BADSUM;
        end
      end
      default: begin
      end
    endcase
    res.good_frame_count = frame_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      previous_byte <= 8'd0;
      frame_length  <= 8'd0;
      byte_index    <= 8'd0;
      running_sum   <= 8'd0;
      frame_counter <= 32'd0;
    end else if (step) begin
      phase         <= phase_next;
      previous_byte <= rx_byte;
      frame_length  <= frame_length_next;
      byte_index    <= byte_index_next;
      running_sum   <= running_sum_next;
      frame_counter <= frame_counter_next;
    end
  end

endmodule

>>> hdl/slcfp_out_reg.sv
module slcfp_out_reg
  import slcfp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    free,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t res_q
);

  assign free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Count is cleared so it always matches the parser's counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_q.good_frame_count <= 32'd0;
    end else if (load) begin
      res_q <= res;
    end
  end

endmodule

>>> hdl/sync_length_checksum_frame_parser.sv
// Path: the input register holds the accepted byte item, then its result is loaded into the result register.
// Throughput: 1 byte item per cycle while results are taken; the phase machine and running sum update together.
// Result stall backs up through the input register; each side holds one item.
// Reset (rst, synchronous, active high): parser hunts for sync, sums, index and
// good frame count clear, sync bytes return to 170 and 85.
`include "sync_length_checksum_frame_parser_defines.svh"

module sync_length_checksum_frame_parser
  import slcfp_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_ready,
  input  logic [7:0]             rx_byte,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic                   payload_valid,
  output logic [7:0]             payload_byte,
  output logic [7:0]             payload_index,
  output logic [2:0]             frame_event,
  output logic [31:0]            good_frame_count,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data
);

  logic [7:0] sync_first_q;
  logic [7:0] sync_second_q;
  logic       full;
  logic [7:0] byte_q;
  logic       free;
  logic       step;
  result_t    res;
  result_t    res_q;

  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first_q  <= SYNC_FIRST_RST;
      sync_second_q <= SYNC_SECOND_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  sync_first_q  <= cfg_data;
        CFG_SYNC_SECOND: sync_second_q <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Advance the held byte when the result register can take its result.
  assign step = full && free;

  slcfp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .rx_byte    (rx_byte),
    .take       (step),
    .full       (full),
    .byte_q     (byte_q)
  );

  slcfp_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .rx_byte     (byte_q),
    .sync_first  (sync_first_q),
    .sync_second (sync_second_q),
    .res         (res)
  );

  slcfp_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (step),
    .res          (res),
    .free         (free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .res_q        (res_q)
  );

  assign payload_valid    = res_q.payload_valid;
  assign payload_byte     = res_q.payload_byte;
  assign payload_index    = res_q.payload_index;
  assign frame_event      = res_q.frame_event;
  assign good_frame_count = res_q.good_frame_count;

  `SLCFP_NEVER(a_no_overwrite, full && !free && byte_ready, "input register overwritten while blocked")
  `SLCFP_ASSERT(a_payload_no_event, step && res.payload_valid |-> res.frame_event == EV_NONE, "payload byte with frame event")
  `SLCFP_ASSERT(a_count_only_good, step && res.frame_event != EV_GOOD |-> res.good_frame_count == good_frame_count, "good frame count moved without good frame")

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import slcfp_pkg::*;

  localparam int TOTAL_ITEMS  = 620;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 6;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   byte_valid = 1'b0;
  logic                   byte_ready;
  logic [7:0]             rx_byte = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  logic                   payload_valid;
  logic [7:0]             payload_byte;
  logic [7:0]             payload_index;
  logic [2:0]             frame_event;
  logic [31:0]            good_frame_count;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0]             cfg_data = '0;

  // Parser mirror: sync registers and frame state at their reset values
  logic [7:0]  sync_first_q  = SYNC_FIRST_RST;
  logic [7:0]  sync_second_q = SYNC_SECOND_RST;
  phase_t      phase_q       = PH_HUNT;
  logic [7:0]  prev_byte_q   = '0;
  logic [7:0]  length_q      = '0;
  logic [7:0]  index_q       = '0;
  logic [7:0]  sum_q         = '0;
  logic [31:0] good_count_q  = '0;
  result_t     parsed_results[$];

  int          errors      = 0;
  int          items_sent  = 0;
  int          burst_left  = 0;
  int          max_gap     = 4;
  logic [7:0]  last_sent   = '0;
  logic [15:0] stall_pattern = 16'hFFFF;
  logic [3:0]  stall_pos   = '0;

  sync_length_checksum_frame_parser uut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .rx_byte(rx_byte),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .payload_valid(payload_valid),
    .payload_byte(payload_byte),
    .payload_index(payload_index),
    .frame_event(frame_event),
    .good_frame_count(good_frame_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void parse_byte(input logic [7:0] b);
    result_t r;
    logic    pair;
    r = '0;
    r.frame_event = EV_NONE;
    pair = (prev_byte_q == sync_first_q) && (b == sync_second_q);
    case (phase_q)
      PH_HUNT: begin
        if (pair) phase_q = PH_LEN;
        index_q = '0;
      end
      PH_LEN: begin
        length_q = b;
        sum_q = b;
        index_q = '0;
        phase_q = PH_DATA;
      end
      PH_DATA: begin
        if (pair) begin
          phase_q = PH_LEN;
          index_q = '0;
          r.frame_event = EV_RESYNC;
        end else if (index_q < length_q) begin
          if (index_q < MAX_PAYLOAD_DEF) begin
            r.payload_valid = 1'b1;
            r.payload_byte = b;
            r.payload_index = index_q;
            sum_q = sum_q + b;
            index_q = index_q + 8'd1;
          end else begin
            phase_q = PH_HUNT;
            index_q = '0;
            r.frame_event = EV_OVER;
          end
        end else begin
          if (sum_q == b) begin
            good_count_q = good_count_q + 32'd1;
            r.frame_event = EV_GOOD;
          end else begin
            r.frame_event = EV_BADSUM;
          end
          phase_q = PH_HUNT;
          index_q = '0;
        end
      end
      default: begin
        phase_q = PH_HUNT;
        index_q = '0;
      end
    endcase
    prev_byte_q = b;
    r.good_frame_count = good_count_q;
    parsed_results.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    errors++;
    if (errors <= 40)
      $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (parsed_results.size() == 0) begin
        report_mismatch("unexpected result", 0, 1);
      end else begin
        want = parsed_results.pop_front();
        if (payload_valid !== want.payload_valid)
          report_mismatch("payload_valid", want.payload_valid, payload_valid);
        if (payload_byte !== want.payload_byte)
          report_mismatch("payload_byte", want.payload_byte, payload_byte);
        if (payload_index !== want.payload_index)
          report_mismatch("payload_index", want.payload_index, payload_index);
        if (frame_event !== want.frame_event)
          report_mismatch("frame_event", want.frame_event, frame_event);
        if (good_frame_count !== want.good_frame_count)
          report_mismatch("good_frame_count", want.good_frame_count, good_frame_count);
      end
    end
    result_ready <= stall_pattern[stall_pos];
    stall_pos <= stall_pos + 4'd1;
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, max_gap);
      if (gap != 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    byte_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!byte_ready);
    parse_byte(b);
    last_sent = b;
    items_sent++;
    burst_left--;
  endtask

  task automatic wait_idle();
    byte_valid <= 1'b0;
    while (parsed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_SYNC_FIRST) sync_first_q = val;
    else if (idx == CFG_SYNC_SECOND) sync_second_q = val;
  endtask

  task automatic set_sync(input logic [7:0] first, input logic [7:0] second);
    write_reg(CFG_SYNC_FIRST, first);
    write_reg(CFG_SYNC_SECOND, second);
  endtask

  // Stop after cut payload bytes when cut is in range; no checksum then.
  task automatic send_frame(input logic [7:0] len, input bit bad_sum, input int cut);
    int         n;
    logic [7:0] sum;
    logic [7:0] b;
    n = (len > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF + 1 : len;
    send_byte(sync_first_q);
    send_byte(sync_second_q);
    send_byte(len);
    sum = len;
    for (int i = 0; i < n; i++) begin
      if (i == cut) return;
      b = $urandom;
      // keep the payload free of a sync pair
      if (last_sent == sync_first_q && b == sync_second_q) b = b ^ 8'h01;
      send_byte(b);
      sum = sum + b;
    end
    if (len <= MAX_PAYLOAD_DEF)
      send_byte(bad_sum ? sum + 8'($urandom_range(1, 255)) : sum);
  endtask

  task automatic test_default_sync();
    send_byte(8'h00);
    send_byte(sync_second_q);
    send_byte(sync_first_q);
    send_frame(8'd0, 1'b0, -1);
    send_byte(sync_first_q);
    send_byte(sync_second_q);
    send_byte(8'd2);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_frame(8'd3, 1'b1, -1);
    send_frame(8'd0, 1'b1, -1);
  endtask

  task automatic test_resync();
    // length byte equal to the first sync byte starts a new pair
    send_byte(sync_first_q);
    send_byte(sync_second_q);
    send_byte(sync_first_q);
    send_byte(sync_second_q);
    send_byte(8'd1);
    send_byte(8'h5A);
    send_byte(8'h5B);
    send_frame(8'd6, 1'b0, 2);
    send_frame(8'd2, 1'b0, -1);
  endtask

  task automatic test_overflow();
    // length equal to the second sync byte, beyond the payload bound
    send_frame(sync_second_q, 1'b0, -1);
    send_frame(8'(MAX_PAYLOAD_DEF), 1'b0, -1);
  endtask

  task automatic test_config_registers();
    set_sync(8'h00, 8'hFF);
    send_byte(SYNC_FIRST_RST);
    send_byte(SYNC_SECOND_RST);
    send_frame(8'd4, 1'b0, -1);
    write_reg(CFG_INDEX_W'($urandom_range(CFG_SYNC_SECOND + 1, 254)), 8'($urandom));
    write_reg({CFG_INDEX_W{1'b1}}, 8'($urandom));
    send_frame(8'd3, 1'b0, -1);
    set_sync(8'h3C, 8'h3C);
    send_frame(8'd2, 1'b0, -1);
    send_frame(8'd1, 1'b1, -1);
  endtask

  task automatic test_random_frames();
    int         r;
    int         target;
    logic [7:0] len;
    logic [7:0] first;
    logic [7:0] second;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          first = SYNC_FIRST_RST;
          second = SYNC_SECOND_RST;
        end
        1: begin
          first = 8'h00;
          second = 8'hFF;
        end
        2: begin
          first = 8'hFF;
          second = 8'h00;
        end
        3: begin
          first = 8'h00;
          second = 8'h00;
        end
        4: begin
          first = 8'hFF;
          second = 8'hFF;
        end
        default: begin
          first = $urandom;
          second = $urandom;
        end
      endcase
      set_sync(first, second);
      if (p == 0) begin
        stall_pattern = 16'hFFFF;
        max_gap = 0;
      end else begin
        stall_pattern = 16'($urandom) | 16'h0001;
        max_gap = $urandom_range(1, 8);
      end
      target = items_sent + TOTAL_ITEMS / PHASES;
      while (items_sent < target) begin
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) len = 8'($urandom_range(13, MAX_PAYLOAD_DEF));
        else len = 8'($urandom_range(0, 12));
        if (r < 60) send_frame(len, 1'b0, -1);
        else if (r < 75) send_frame(len, 1'b1, -1);
        else if (r < 83) send_frame(len, 1'b0, $urandom_range(0, len));
        else if (r < 86) send_frame(8'($urandom_range(MAX_PAYLOAD_DEF + 1, 255)), 1'b0, -1);
        else repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    stall_pattern = 16'hB6D9;
    test_default_sync();
    test_resync();
    test_overflow();
    test_config_registers();
    test_random_frames();
    wait_idle();
    if (errors == 0 && parsed_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/slcfp_pkg.sv
hdl/slcfp_in_reg.sv
hdl/slcfp_parser.sv
hdl/slcfp_out_reg.sv
hdl/sync_length_checksum_frame_parser.sv
test/testbench.sv
